@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fqmtf_pkg.sv @@
// Types, codes and helpers of the move-to-front queue.
package fqmtf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Request codes.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_MTF = 2'd2;
  localparam logic [1:0] OP_QRY = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SRCH,
    ST_SHF,
    ST_FRONT,
    ST_RESP
  } fsm_t;

  // Circular address: base plus offset, both below QUEUE_DEPTH.
  function automatic ptr_t wrap_add(input ptr_t base, input ptr_t off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/fqmtf_if.sv @@
// Handshake channel interfaces for requests and results.
interface fqmtf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
  modport mon    (input valid, input op, input value, input ready);
endinterface

interface fqmtf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] head_value;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic        found;
  logic [1:0]  status;

  modport source (output valid, output head_value, output entry_count, output is_empty,
                  output found, output status, input ready);
  modport sink   (input valid, input head_value, input entry_count, input is_empty,
                  input found, input status, output ready);
  modport mon    (input valid, input head_value, input entry_count, input is_empty,
                  input found, input status, input ready);
endinterface

@@ rtl/fqmtf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fqmtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/fifo_queue_move_to_front.sv @@
// Top level of the bounded queue with move-to-front, entries held in one RAM.
//
//   channel   direction  contents
//   in_req    sink       op, value
//   out_rsp   source     head_value, entry_count, is_empty, found, status
//
// Entries sit in a circular buffer in one RAM; a head register caches entry 0.
// Query, enqueue, rejected requests and a hit at the head go straight to the result state;
// dequeue first fetches the new head, unless it empties the queue. Move-to-front searches
// one entry a cycle, then moves each entry ahead of the match back by one a cycle and writes
// the value at the head. Reset (synchronous, active low) empties the queue, not the RAM.
// A new request is taken while the previous result still waits in the output register.
module fifo_queue_move_to_front (
  input  logic        clk,
  input  logic        rst_n,
  fqmtf_in_if.sink    in_req,
  fqmtf_out_if.source out_rsp
);
  import fqmtf_pkg::*;

  fsm_t  state_r, state_nxt;
  ptr_t  head_r, head_nxt;
  cnt_t  count_r, count_nxt;
  data_t hval_r, hval_nxt;
  data_t val_r, val_nxt;
  ptr_t  idx_r, idx_nxt;
  logic  found_r, found_nxt;
  logic [1:0] status_r, status_nxt;

  logic        ov_r, ov_nxt;
  data_t       o_head_r, o_head_nxt;
  cnt_t        o_count_r, o_count_nxt;
  logic        o_empty_r, o_empty_nxt;
  logic        o_found_r, o_found_nxt;
  logic [1:0]  o_status_r, o_status_nxt;

  logic  rd_en, wr_en;
  ptr_t  rd_addr, wr_addr;
  data_t rd_data, wr_data;

  fqmtf_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    hval_nxt     = hval_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    ov_nxt       = ov_r && !out_rsp.ready;
    o_head_nxt   = o_head_r;
    o_count_nxt  = o_count_r;
    o_empty_nxt  = o_empty_r;
    o_found_nxt  = o_found_r;
    o_status_nxt = o_status_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = in_req.value;

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          val_nxt    = in_req.value;
          found_nxt  = 1'b0;
          status_nxt = STAT_OK;
          state_nxt  = ST_RESP;
          case (in_req.op)
            OP_ENQ: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_add(head_r, count_r[PTR_W-1:0]);
                count_nxt = count_r + 1'b1;
                if (count_r == '0) begin
                  hval_nxt = in_req.value;
                end
              end
            end
            OP_DEQ: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                head_nxt  = wrap_add(head_r, PTR_W'(1));
                count_nxt = count_r - 1'b1;
                if (count_r != CNT_W'(1)) begin
                  // The new head has to be fetched before the result can go out.
                  rd_en     = 1'b1;
                  rd_addr   = wrap_add(head_r, PTR_W'(1));
                  state_nxt = ST_HEAD;
                end
              end
            end
            OP_MTF: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (hval_r == in_req.value) begin
                found_nxt = 1'b1;
              end else if (count_r != CNT_W'(1)) begin
                rd_en     = 1'b1;
                rd_addr   = wrap_add(head_r, PTR_W'(1));
                idx_nxt   = PTR_W'(1);
                state_nxt = ST_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_HEAD: begin
        hval_nxt  = rd_data;
        state_nxt = ST_RESP;
      end

      ST_SRCH: begin
        // rd_data holds the entry at position idx_r.
        if (rd_data == val_r) begin
          found_nxt = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = wrap_add(head_r, idx_r - 1'b1);
          state_nxt = ST_SHF;
        end else if (CNT_W'(idx_r) + 1'b1 == count_r) begin
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = wrap_add(head_r, idx_r + 1'b1);
        end
      end

      ST_SHF: begin
        // rd_data holds the entry at idx_r - 1; it moves back to idx_r.
        wr_en   = 1'b1;
        wr_addr = wrap_add(head_r, idx_r);
        wr_data = rd_data;
        idx_nxt = idx_r - 1'b1;
        if (idx_r == PTR_W'(1)) begin
          state_nxt = ST_FRONT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = wrap_add(head_r, idx_r - PTR_W'(2));
        end
      end

      ST_FRONT: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = val_r;
        hval_nxt  = val_r;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt       = 1'b1;
          o_head_nxt   = (count_r != '0) ? hval_r : '0;
          o_count_nxt  = count_r;
          o_empty_nxt  = (count_r == '0);
          o_found_nxt  = found_r;
          o_status_nxt = status_r;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hval_r     <= hval_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    o_head_r   <= o_head_nxt;
    o_count_r  <= o_count_nxt;
    o_empty_r  <= o_empty_nxt;
    o_found_r  <= o_found_nxt;
    o_status_r <= o_status_nxt;
  end

  assign out_rsp.valid       = ov_r;
  assign out_rsp.head_value  = o_head_r;
  assign out_rsp.entry_count = o_count_r;
  assign out_rsp.is_empty    = o_empty_r;
  assign out_rsp.found       = o_found_r;
  assign out_rsp.status      = o_status_r;

endmodule

@@ rtl/fqmtf_chk.sv @@
// Port-level checker for the move-to-front queue and its bind to the top level.
`include "assert_macros.svh"

module fqmtf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input fqmtf_pkg::data_t   out_head_value,
  input fqmtf_pkg::cnt_t    out_entry_count,
  input logic               out_is_empty,
  input logic               out_found,
  input logic [1:0]         out_status
);
  import fqmtf_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_head_value) && $stable(out_entry_count),
    "result changed before its transfer")
  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid,
    out_is_empty == (out_entry_count == '0), "empty flag disagrees with count")
  `ASSERT_IMPL(a_empty_head, clk, rst_n, out_valid && out_is_empty,
    out_head_value == '0 && !out_found, "empty queue shows a head or a match")
  `ASSERT_IMPL(a_found_ok, clk, rst_n, out_valid && out_found,
    out_status == STAT_OK, "match reported with an error status")
  `ASSERT_IMPL(a_count_max, clk, rst_n, out_valid,
    out_entry_count <= CNT_W'(QUEUE_DEPTH), "count exceeds queue depth")

endmodule

bind fifo_queue_move_to_front fqmtf_chk u_fqmtf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_head_value (out_rsp.head_value),
  .out_entry_count(out_rsp.entry_count),
  .out_is_empty   (out_rsp.is_empty),
  .out_found      (out_rsp.found),
  .out_status     (out_rsp.status)
);

@@ verif/tb_fifo_queue_move_to_front.sv @@
// Testbench for the move-to-front queue: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_fifo_queue_move_to_front;
  import fqmtf_pkg::*;

  typedef struct {
    logic [1:0]  op;
    data_t       value;
    int unsigned gap;
  } req_t;

  typedef struct packed {
    data_t      head_value;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       found;
    logic [1:0] status;
  } rsp_t;

  logic clk;
  logic rst_n;

  fqmtf_in_if  in_req ();
  fqmtf_out_if out_rsp ();

  fifo_queue_move_to_front dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  req_t        pending[$];
  rsp_t        rsp_expected[$];
  data_t       held[$];
  int unsigned pending_total;
  int unsigned in_issued;
  int unsigned in_taken;
  int unsigned in_wait;
  int unsigned out_taken;
  int unsigned out_ack;
  int unsigned out_wait;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  task automatic queue_request(input logic [1:0] op, input data_t value);
    req_t r;
    r.op = op;
    r.value = value;
    // Every fourth window of 150 requests runs back to back.
    r.gap = ((pending_total / 150) % 4 == 1) ? 0 : $urandom_range(0, 6);
    pending.push_back(r);
    pending_total++;
  endtask

  // Applies one request to the shadow queue and returns the result it must produce.
  function automatic rsp_t apply_request(input logic [1:0] op, input data_t value);
    rsp_t r;
    int   hit;
    r = '0;
    hit = -1;
    case (op)
      OP_ENQ: begin
        if (held.size() >= QUEUE_DEPTH) r.status = STAT_FULL;
        else held.push_back(value);
      end
      OP_DEQ: begin
        if (held.size() == 0) r.status = STAT_EMPTY;
        else void'(held.pop_front());
      end
      OP_MTF: begin
        if (held.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          foreach (held[i]) begin
            if (hit < 0 && held[i] == value) hit = i;
          end
          if (hit >= 0) begin
            held.delete(hit);
            held.push_front(value);
            r.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(held.size());
    r.is_empty = (held.size() == 0);
    r.head_value = r.is_empty ? '0 : held[0];
    return r;
  endfunction

  // Request driver: holds each item until its transfer, then waits out the next item's gap.
  always @(negedge clk) begin : request_driver
    req_t item;
    if (rst_n) begin
      if (in_req.valid && in_taken != in_issued) begin
        // Current request still waiting for its transfer.
      end else if (pending.size() == 0) begin
        in_req.valid <= 1'b0;
      end else if (in_wait < pending[0].gap) begin
        in_req.valid <= 1'b0;
        in_wait <= in_wait + 1;
      end else begin
        item = pending.pop_front();
        in_req.valid <= 1'b1;
        in_req.op <= item.op;
        in_req.value <= item.value;
        in_wait <= 0;
        in_issued <= in_issued + 1;
      end
    end
  end

  // Result stalls: a new wait is drawn after every transfer, with calm stretches.
  always @(negedge clk) begin : result_ready
    int unsigned w;
    if (rst_n) begin
      if (out_taken != out_ack) begin
        out_ack <= out_taken;
        w = ((out_taken / 200) % 4 == 3) ? 0 : $urandom_range(0, 6);
        out_rsp.ready <= (w == 0);
        out_wait <= (w == 0) ? 0 : w - 1;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        rsp_expected.push_back(apply_request(in_req.op, in_req.value));
        in_taken <= in_taken + 1;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        out_taken <= out_taken + 1;
        if (rsp_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", out_taken));
        end else begin
          want = rsp_expected.pop_front();
          if (out_rsp.head_value !== want.head_value)
            report_mismatch($sformatf("result %0d head_value %h, expected %h", out_taken,
                                      out_rsp.head_value, want.head_value));
          if (out_rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d", out_taken,
                                      out_rsp.entry_count, want.entry_count));
          if (out_rsp.is_empty !== want.is_empty)
            report_mismatch($sformatf("result %0d is_empty %b, expected %b", out_taken,
                                      out_rsp.is_empty, want.is_empty));
          if (out_rsp.found !== want.found)
            report_mismatch($sformatf("result %0d found %b, expected %b", out_taken,
                                      out_rsp.found, want.found));
          if (out_rsp.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d", out_taken,
                                      out_rsp.status, want.status));
        end
      end
    end
  end

  initial begin : stimulus
    data_t       pool[8];
    int unsigned mode;
    int unsigned pick;
    logic [1:0]  op;
    data_t       v;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.op = OP_QRY;
    in_req.value = '0;
    out_rsp.ready = 1'b0;
    pending_total = 0;
    in_issued = 0;
    in_taken = 0;
    in_wait = 0;
    out_taken = 0;
    out_ack = 0;
    out_wait = 0;
    mismatches = 0;

    // Empty queue: query, dequeue and move-to-front are all flagged or plain.
    queue_request(OP_QRY, 16'hFFFF);
    queue_request(OP_DEQ, 16'h0000);
    queue_request(OP_MTF, 16'h0000);
    queue_request(OP_ENQ, 16'h0000);
    queue_request(OP_ENQ, 16'hFFFF);
    queue_request(OP_ENQ, 16'h1234);
    queue_request(OP_ENQ, 16'hFFFF);
    // Hit deep in the queue, then the same value already at the head.
    queue_request(OP_MTF, 16'h1234);
    queue_request(OP_MTF, 16'h1234);
    // Duplicates: only the first copy moves.
    queue_request(OP_MTF, 16'hFFFF);
    queue_request(OP_MTF, 16'hABCD);
    for (int i = 0; i < 12; i++) begin
      queue_request(OP_ENQ, data_t'({4'(i), 12'hA5C} ^ 16'h5A00));
    end
    queue_request(OP_ENQ, 16'h5555);
    queue_request(OP_MTF, data_t'({4'd11, 12'hA5C} ^ 16'h5A00));
    queue_request(OP_QRY, 16'h0000);

    // Random segments lean toward filling, draining or neither, so the queue
    // swings between empty and full; a small value pool keeps searches hitting.
    for (int seg = 0; seg < 45; seg++) begin
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 8; k++) begin
        if (seg == 0 || $urandom_range(0, 3) == 0) pool[k] = data_t'($urandom);
      end
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (mode == 0) begin
          op = (pick < 55) ? OP_ENQ : (pick < 70) ? OP_DEQ : (pick < 95) ? OP_MTF : OP_QRY;
        end else if (mode == 1) begin
          op = (pick < 15) ? OP_ENQ : (pick < 60) ? OP_DEQ : (pick < 95) ? OP_MTF : OP_QRY;
        end else begin
          op = (pick < 35) ? OP_ENQ : (pick < 60) ? OP_DEQ : (pick < 92) ? OP_MTF : OP_QRY;
        end
        v = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : data_t'($urandom);
        queue_request(op, v);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_taken != in_issued || rsp_expected.size() != 0) begin
      @(posedge clk);
    end
    // A stray late result would show up within this window.
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fqmtf_pkg.sv
rtl/fqmtf_if.sv
rtl/fqmtf_ram.sv
rtl/fifo_queue_move_to_front.sv
rtl/fqmtf_chk.sv
verif/tb_fifo_queue_move_to_front.sv
